// File: rtl/rcsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_pkg
// Shared types and constants of the Rice code stream decoder.
// ----------------------------------------------------------------------------
package rcsd_pkg;

    localparam int STREAM_W    = 32;
    localparam int VALUE_W     = 32;
    localparam int KW_W        = 5;
    localparam int WIDTH_W     = 6;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int RCNT_W      = 6;

    localparam logic [CFG_IDX_W-1:0] REG_CODE_WIDTH    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PREFIXED_MODE = 1'd1;

    localparam logic [WIDTH_W-1:0] PREFIX_K     = 6'd2;
    localparam logic [VALUE_W-1:0] PREFIX_Q_SAT = 32'd9;
    localparam logic [VALUE_W-1:0] MAX_WIDTH    = 32'd32;
    localparam logic [RCNT_W-1:0]  RESULT_CAP   = 6'd32;
    localparam logic [KW_W-1:0]    RST_CODE_WIDTH = 5'd2;

    typedef enum logic [1:0] {
        PH_UNARY       = 2'd0,
        PH_PREFIX_LOW  = 2'd1,
        PH_VALUE_UNARY = 2'd2,
        PH_VALUE_LOW   = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ENG_IDLE  = 2'd0,
        ENG_RUN   = 2'd1,
        ENG_FLUSH = 2'd2
    } eng_state_t;

    typedef struct packed {
        logic [KW_W-1:0] code_width;
        logic            prefixed_mode;
    } cfg_t;

    typedef struct packed {
        logic                valid;
        logic [STREAM_W-1:0] word;
    } word_slot_t;

endpackage : rcsd_pkg
`default_nettype wire

// File: rtl/rcsd_word_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_word_queue
// Front part: accepts stream words and holds them for the bit engine.
// ----------------------------------------------------------------------------
module rcsd_word_queue
    import rcsd_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [STREAM_W-1:0] s_tdata,   // stream_word
    output word_slot_t               head,
    input  wire logic                head_pop
);

    logic [STREAM_W-1:0] mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push, pop;

    assign s_tready   = (count_reg < QCNT_W'(QUEUE_DEPTH));
    assign push       = s_tvalid && s_tready;
    assign pop        = head_pop && (count_reg != '0);
    assign head.valid = (count_reg != '0);
    assign head.word  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= s_tdata;
        end
    end

endmodule : rcsd_word_queue
`default_nettype wire

// File: rtl/rcsd_bit_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rcsd_bit_engine
// Back part: walks a word a bit per cycle when the output is free, decodes
// Rice codes and drives the result channel, marking each word's last result.
// ----------------------------------------------------------------------------
module rcsd_bit_engine
    import rcsd_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire cfg_t               cfg,
    input  wire word_slot_t         head,
    output logic                    head_pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [VALUE_W-1:0]      m_tdata,   // decoded_value
    output logic                    m_tuser,   // bad_width
    output logic                    m_tlast    // last_of_word
);

    localparam int EXT_W = (WORD_BITS > STREAM_W) ? WORD_BITS : STREAM_W;
    localparam int CNT_W = $clog2(WORD_BITS);

    eng_state_t           state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [VALUE_W-1:0]   partial_reg, partial_next;
    logic [WIDTH_W-1:0]   tail_reg, tail_next;
    logic [WIDTH_W-1:0]   active_reg, active_next;
    logic [WORD_BITS-1:0] shift_reg, shift_next;
    logic [CNT_W-1:0]     bit_cnt_reg, bit_cnt_next;
    logic [RCNT_W-1:0]    res_cnt_reg, res_cnt_next;
    logic                 pend_valid_reg, pend_valid_next;
    logic [VALUE_W-1:0]   pend_value_reg, pend_value_next;
    logic                 pend_bad_reg, pend_bad_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   m_data_reg, m_data_next;
    logic                 m_user_reg, m_user_next;
    logic                 m_last_reg, m_last_next;

    logic [EXT_W-1:0]     word_ext;
    logic                 bit_in, last_bit, out_free, emit;

    phase_t               dec_phase;
    logic [VALUE_W-1:0]   dec_partial, dec_value, shifted;
    logic [WIDTH_W-1:0]   dec_tail, dec_active, tail_dec, unary_k;
    logic                 dec_emit, dec_bad;

    assign word_ext = EXT_W'(head.word);
    assign bit_in   = shift_reg[WORD_BITS-1];
    assign last_bit = (bit_cnt_reg == CNT_W'(WORD_BITS - 1));
    assign out_free = !m_valid_reg || m_tready;
    assign shifted  = {partial_reg[VALUE_W-2:0], bit_in};

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // one stream bit through the decoder
    always_comb begin
        dec_phase   = phase_reg;
        dec_partial = partial_reg;
        dec_tail    = tail_reg;
        dec_active  = active_reg;
        dec_emit    = 1'b0;
        dec_value   = partial_reg;
        dec_bad     = 1'b0;
        tail_dec    = tail_reg - 1'b1;
        unary_k     = (phase_reg == PH_VALUE_UNARY) ? active_reg : WIDTH_W'(cfg.code_width);
        case (phase_reg)
            PH_UNARY, PH_VALUE_UNARY: begin
                if (phase_reg == PH_UNARY && cfg.prefixed_mode) begin
                    if (bit_in) begin
                        dec_tail  = PREFIX_K;
                        dec_phase = PH_PREFIX_LOW;
                    end else if (partial_reg < PREFIX_Q_SAT) begin
                        dec_partial = partial_reg + 1'b1;
                    end
                end else if (bit_in) begin
                    // end of unary part
                    if (unary_k == '0) begin
                        dec_emit    = 1'b1;
                        dec_value   = partial_reg;
                        dec_partial = '0;
                        dec_phase   = PH_UNARY;
                    end else begin
                        dec_active = unary_k;
                        dec_tail   = unary_k;
                        dec_phase  = PH_VALUE_LOW;
                    end
                end else begin
                    dec_partial = partial_reg + 1'b1;
                end
            end
            PH_PREFIX_LOW: begin
                dec_tail = tail_dec;
                if (tail_dec == '0) begin
                    if (shifted > MAX_WIDTH) begin
                        dec_emit  = 1'b1;
                        dec_value = '0;
                        dec_bad   = 1'b1;
                        dec_phase = PH_UNARY;
                    end else begin
                        dec_active = shifted[WIDTH_W-1:0];
                        dec_phase  = PH_VALUE_UNARY;
                    end
                    dec_partial = '0;
                end else begin
                    dec_partial = shifted;
                end
            end
            PH_VALUE_LOW: begin
                if (tail_reg != '0) begin
                    dec_tail = tail_dec;
                end
                if (tail_reg <= WIDTH_W'(1)) begin
                    dec_emit    = 1'b1;
                    dec_value   = shifted;
                    dec_partial = '0;
                    dec_phase   = PH_UNARY;
                end else begin
                    dec_partial = shifted;
                end
            end
            default: begin
                dec_phase = PH_UNARY;
            end
        endcase
    end

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        partial_next    = partial_reg;
        tail_next       = tail_reg;
        active_next     = active_reg;
        shift_next      = shift_reg;
        bit_cnt_next    = bit_cnt_reg;
        res_cnt_next    = res_cnt_reg;
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        pend_bad_next   = pend_bad_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        m_last_next     = m_last_reg;
        head_pop        = 1'b0;
        emit            = dec_emit && (res_cnt_reg < RESULT_CAP);
        case (state_reg)
            ENG_IDLE: begin
                if (head.valid) begin
                    head_pop     = 1'b1;
                    shift_next   = word_ext[WORD_BITS-1:0];
                    bit_cnt_next = '0;
                    res_cnt_next = '0;
                    state_next   = ENG_RUN;
                end
            end
            ENG_RUN: begin
                if (out_free) begin
                    phase_next   = dec_phase;
                    partial_next = dec_partial;
                    tail_next    = dec_tail;
                    active_next  = dec_active;
                    shift_next   = {shift_reg[WORD_BITS-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg + 1'b1;
                    if (emit) begin
                        res_cnt_next = res_cnt_reg + 1'b1;
                        // the held result is known not to be the last one
                        if (pend_valid_reg) begin
                            m_valid_next = 1'b1;
                            m_data_next  = pend_value_reg;
                            m_user_next  = pend_bad_reg;
                            m_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_value_next = dec_value;
                        pend_bad_next   = dec_bad;
                    end
                    if (last_bit) begin
                        state_next = (emit || pend_valid_reg) ? ENG_FLUSH : ENG_IDLE;
                    end
                end
            end
            ENG_FLUSH: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_data_next     = pend_value_reg;
                    m_user_next     = pend_bad_reg;
                    m_last_next     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ENG_IDLE;
                end
            end
            default: begin
                state_next = ENG_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ENG_IDLE;
            phase_reg      <= PH_UNARY;
            partial_reg    <= '0;
            tail_reg       <= '0;
            active_reg     <= '0;
            bit_cnt_reg    <= '0;
            res_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            partial_reg    <= partial_next;
            tail_reg       <= tail_next;
            active_reg     <= active_next;
            bit_cnt_reg    <= bit_cnt_next;
            res_cnt_reg    <= res_cnt_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg      <= shift_next;
        pend_value_reg <= pend_value_next;
        pend_bad_reg   <= pend_bad_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        m_last_reg     <= m_last_next;
    end

endmodule : rcsd_bit_engine
`default_nettype wire

// File: rtl/rice_code_stream_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rice_code_stream_decoder_core
// Rice code decoder for a stream of words, plain or width-prefixed codes.
// ----------------------------------------------------------------------------
// Usage:
//   s_* channel carries stream words, first stream bit in the top bit.
//   m_* channel carries one decoded value per transfer; m_tuser flags a
//   prefixed width above 32 (value 0), m_tlast marks the last result of a
//   word. Codes may span words; partial codes are kept between words.
//   cfg_wr_* writes code_width (index 0) and prefixed_mode (index 1); the user
//   must write only while the block is idle, which the block does not enforce.
// Timing:
//   A two-word queue takes words while the bit engine works. The engine
//   loads a word, then takes one stream bit per cycle while the output is
//   free, and last flushes the held result when the word produced any.
//   Results of a word leave at most one per cycle; the last one is registered
//   out of the flush state once the output is free.
// Reset and stall:
//   aresetn clears the queue, decode state and output; code_width returns
//   to 2 and prefixed_mode to 0. While a result waits with m_tready low the
//   engine pauses on its current bit and the queue keeps filling up to two
//   words.
// ----------------------------------------------------------------------------
module rice_code_stream_decoder_core
    import rcsd_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [STREAM_W-1:0]   s_tdata,   // stream_word
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [VALUE_W-1:0]         m_tdata,   // decoded_value
    output logic                       m_tuser,   // bad_width
    output logic                       m_tlast    // last_of_word
);

    logic [KW_W-1:0] code_width_reg, code_width_next;
    logic            prefixed_mode_reg, prefixed_mode_next;
    cfg_t            cfg;
    word_slot_t      head;
    logic            head_pop;

    always_comb begin
        code_width_next    = code_width_reg;
        prefixed_mode_next = prefixed_mode_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_CODE_WIDTH:    code_width_next    = cfg_wr_data[KW_W-1:0];
                REG_PREFIXED_MODE: prefixed_mode_next = cfg_wr_data[0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            code_width_reg    <= RST_CODE_WIDTH;
            prefixed_mode_reg <= 1'b0;
        end else begin
            code_width_reg    <= code_width_next;
            prefixed_mode_reg <= prefixed_mode_next;
        end
    end

    assign cfg.code_width    = code_width_reg;
    assign cfg.prefixed_mode = prefixed_mode_reg;

    rcsd_word_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .head     (head),
        .head_pop (head_pop)
    );

    rcsd_bit_engine #(
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .head     (head),
        .head_pop (head_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule : rice_code_stream_decoder_core
`default_nettype wire

// File: bench/rcsd_stream_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcsd_stream_checker
// Watches the register port and both stream channels of the Rice decoder,
// decodes every accepted stream word on its own bit by bit and compares
// each result transfer against the oldest value still due.
// ----------------------------------------------------------------------------
module rcsd_stream_checker
    import rcsd_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [STREAM_W-1:0]   s_tdata,   // stream_word
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [VALUE_W-1:0]    m_tdata,   // decoded_value
    input  wire logic                  m_tuser,   // bad_width
    input  wire logic                  m_tlast,   // last_of_word
    output int                         error_count,
    output int                         pending_results,
    output int                         words_seen,
    output int                         values_checked,
    output int                         width_flags_seen
);

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               bad_width;
        logic               last_of_word;
    } rice_value_t;

    rice_value_t values_due[$];

    // register copies
    logic [KW_W-1:0]    code_width;
    logic               prefixed_mode;

    // decode state
    logic [VALUE_W-1:0] acc;
    phase_t             phase;
    logic [WIDTH_W-1:0] bits_left;
    logic [WIDTH_W-1:0] cur_width;
    int                 word_results;

    task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] want,
                                   input logic [VALUE_W-1:0] got);
        $display("[%0t] mismatch on %s: expected %h, got %h", $time, what, want, got);
        error_count++;
    endtask

    task automatic emit(input logic [VALUE_W-1:0] v, input logic bad);
        rice_value_t r;
        if (word_results < RESULT_CAP) begin
            r.value        = v;
            r.bad_width    = bad;
            r.last_of_word = 1'b0;
            values_due.push_back(r);
            word_results++;
        end
    endtask

    // stop bit of a unary part: zero width emits at once, else collect low bits
    task automatic close_unary(input logic [WIDTH_W-1:0] k);
        if (k == '0) begin
            emit(acc, 1'b0);
            acc   = '0;
            phase = PH_UNARY;
        end else begin
            cur_width = k;
            bits_left = k;
            phase     = PH_VALUE_LOW;
        end
    endtask

    task automatic shift_in(input logic b);
        case (phase)
            PH_UNARY: begin
                if (prefixed_mode) begin
                    if (b) begin
                        bits_left = PREFIX_K;
                        phase     = PH_PREFIX_LOW;
                    end else if (acc < PREFIX_Q_SAT) begin
                        acc = acc + 1'b1;
                    end
                end else if (b) begin
                    close_unary({1'b0, code_width});
                end else begin
                    acc = acc + 1'b1;
                end
            end
            PH_PREFIX_LOW: begin
                acc       = {acc[VALUE_W-2:0], b};
                bits_left = bits_left - 1'b1;
                if (bits_left == '0) begin
                    if (acc > MAX_WIDTH) begin
                        // value skipped, next bits start a new width prefix
                        emit('0, 1'b1);
                        phase = PH_UNARY;
                    end else begin
                        cur_width = acc[WIDTH_W-1:0];
                        phase     = PH_VALUE_UNARY;
                    end
                    acc = '0;
                end
            end
            PH_VALUE_UNARY: begin
                if (b) begin
                    close_unary(cur_width);
                end else begin
                    acc = acc + 1'b1;
                end
            end
            default: begin
                acc = {acc[VALUE_W-2:0], b};
                if (bits_left != '0) begin
                    bits_left = bits_left - 1'b1;
                end
                if (bits_left == '0) begin
                    emit(acc, 1'b0);
                    acc   = '0;
                    phase = PH_UNARY;
                end
            end
        endcase
    endtask

    task automatic decode_word(input logic [STREAM_W-1:0] word);
        rice_value_t tail;
        word_results = 0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            shift_in(word[i]);
        end
        if (word_results > 0) begin
            tail = values_due.pop_back();
            tail.last_of_word = 1'b1;
            values_due.push_back(tail);
        end
    endtask

    always @(posedge aclk) begin
        rice_value_t want;
        if (!aresetn) begin
            code_width    = RST_CODE_WIDTH;
            prefixed_mode = 1'b0;
            acc           = '0;
            phase         = PH_UNARY;
            bits_left     = '0;
            cur_width     = '0;
            values_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                if (values_due.size() == 0) begin
                    report_mismatch("result transfer with nothing due", '0, m_tdata);
                end else begin
                    want = values_due.pop_front();
                    values_checked++;
                    if (want.bad_width) begin
                        width_flags_seen++;
                    end
                    if (m_tdata !== want.value) begin
                        report_mismatch("decoded_value", want.value, m_tdata);
                    end
                    if (m_tuser !== want.bad_width) begin
                        report_mismatch("bad_width", VALUE_W'(want.bad_width),
                                        VALUE_W'(m_tuser));
                    end
                    if (m_tlast !== want.last_of_word) begin
                        report_mismatch("last_of_word", VALUE_W'(want.last_of_word),
                                        VALUE_W'(m_tlast));
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_CODE_WIDTH:    code_width = cfg_wr_data[KW_W-1:0];
                    REG_PREFIXED_MODE: prefixed_mode = cfg_wr_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                decode_word(s_tdata);
                words_seen++;
            end
        end
        pending_results = values_due.size();
    end

endmodule

// File: bench/tb_rice_code_stream_decoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rice_code_stream_decoder_core
// Drives the Rice decoder with hand-picked stream words, then with words cut
// from randomly encoded Rice streams mixed with raw noise, over plain and
// width-prefixed settings, with changing input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_rice_code_stream_decoder_core;
    import rcsd_pkg::*;

    localparam int WORD_BITS     = 32;
    // long enough for the two queued words and the one in the engine to finish
    localparam int QUIET_CYCLES  = 150;
    localparam int STALL_LIMIT   = 3000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_WORDS   = 19;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_wr_index;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [STREAM_W-1:0]   s_tdata;   // stream_word
    logic                  m_tvalid;
    logic                  m_tready;
    logic [VALUE_W-1:0]    m_tdata;   // decoded_value
    logic                  m_tuser;   // bad_width
    logic                  m_tlast;   // last_of_word

    int error_count;
    int pending_results;
    int words_seen;
    int values_checked;
    int width_flags_seen;

    int unsigned send_idle_pct;
    int unsigned rcv_idle_pct;
    int unsigned idle_cycles = 0;
    int          settings_done = 0;

    // encoder side view of the registers, used to build matching streams
    logic [KW_W-1:0] enc_width;
    logic            enc_prefixed;
    bit              code_bits[$];

    always #6 aclk = ~aclk;

    rice_code_stream_decoder_core #(
        .WORD_BITS (WORD_BITS)
    ) uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast)
    );

    rcsd_stream_checker #(
        .WORD_BITS (WORD_BITS)
    ) decode_check (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_index     (cfg_wr_index),
        .cfg_wr_data      (cfg_wr_data),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast),
        .error_count      (error_count),
        .pending_results  (pending_results),
        .words_seen       (words_seen),
        .values_checked   (values_checked),
        .width_flags_seen (width_flags_seen)
    );

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic send_word(input logic [STREAM_W-1:0] w);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // let every due result arrive, then give words that yield nothing time to finish
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results != 0) begin
            @(negedge aclk);
        end
        repeat (QUIET_CYCLES) @(negedge aclk);
    endtask

    task automatic apply_config(input logic [KW_W-1:0] k, input logic mode);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= REG_CODE_WIDTH;
        cfg_wr_data  <= k;
        @(negedge aclk);
        cfg_wr_index <= REG_PREFIXED_MODE;
        cfg_wr_data  <= {{(CFG_DATA_W - 1){1'b0}}, mode};
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        enc_width     = k;
        enc_prefixed  = mode;
        settings_done++;
    endtask

    task automatic add_code(input int unsigned q, input int unsigned k,
                            input logic [VALUE_W-1:0] r);
        for (int unsigned n = 0; n < q; n++) begin
            code_bits.push_back(1'b0);
        end
        code_bits.push_back(1'b1);
        for (int j = int'(k) - 1; j >= 0; j--) begin
            code_bits.push_back(r[j]);
        end
    endtask

    task automatic add_random_code();
        int unsigned q;
        int unsigned w;
        logic [VALUE_W-1:0] r;
        q = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4) : $urandom_range(5, 80);
        r = $urandom();
        if (!enc_prefixed) begin
            add_code(q, enc_width, r);
        end else begin
            case ($urandom_range(0, 9))
                // long prefix unary part, always too wide
                0: add_code($urandom_range(9, 14), 2, r);
                // widths 33 to 35
                1: add_code(8, 2, $urandom_range(1, 3));
                default: begin
                    w = $urandom_range(0, 32);
                    add_code(w >> 2, 2, w & 3);
                    add_code(q, w, r);
                end
            endcase
        end
    endtask

    // mostly slices of a well-formed code stream, now and then a raw noise word
    task automatic make_word(output logic [STREAM_W-1:0] w);
        if ($urandom_range(0, 3) == 0) begin
            w = $urandom();
        end else begin
            while (code_bits.size() < STREAM_W) begin
                add_random_code();
            end
            for (int j = STREAM_W - 1; j >= 0; j--) begin
                w[j] = code_bits.pop_front();
            end
        end
    endtask

    initial begin
        logic [STREAM_W-1:0] w;
        logic [KW_W-1:0]     k_pick;
        logic                mode_pick;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_index  = REG_CODE_WIDTH;
        cfg_wr_data   = '0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        enc_width     = RST_CODE_WIDTH;
        enc_prefixed  = 1'b0;
        send_idle_pct = 13;
        rcv_idle_pct  = 70;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // plain codes at the width left by reset
        send_word(32'h0000_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h8000_0000);
        send_word(32'h0000_0001);
        drain();

        // width zero: every one bit closes a value
        apply_config(5'd0, 1'b0);
        send_word(32'hFFFF_FFFF);
        send_word(32'h5555_5555);
        send_word(32'h0000_0000);
        send_word(32'h0000_0001);
        drain();

        // widest plain code, low bits spanning words
        apply_config(5'd31, 1'b0);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0000_0001);
        send_word(32'hFFFF_FFFE);
        send_word(32'hAAAA_AAAA);
        drain();

        // prefixed: zero widths, too-wide prefixes, saturating prefix unary, width 32
        apply_config(5'd31, 1'b1);
        send_word(32'h9999_9999);
        send_word(32'h00A0_0000);
        send_word(32'hFFFF_FFFF);
        send_word(32'h0080_0000);
        send_word(32'h4000_0001);
        send_word(32'h0000_0000);
        drain();

        // back to plain with a prefix unary count still held
        apply_config(5'd3, 1'b0);
        send_word(32'h1234_5678);
        send_word(32'hFEDC_BA98);

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p >= 5) begin
                send_idle_pct = 0;
                rcv_idle_pct  = 0;
            end else if (p >= 2) begin
                send_idle_pct = 70;
                rcv_idle_pct  = 13;
            end
            drain();
            k_pick    = (p == 0) ? 5'd0 : (p == 1) ? 5'd31 : KW_W'($urandom_range(0, 31));
            mode_pick = (p >= 2) ? p[0] == 1'b0 : 1'b0;
            apply_config(k_pick, mode_pick);
            repeat (PHASE_WORDS) begin
                make_word(w);
                send_word(w);
            end
        end
        drain();

        $display("covered %0d stream words over %0d register settings", words_seen,
                 settings_done);
        $display("checked %0d decoded values, %0d of them width errors", values_checked,
                 width_flags_seen);
        if (error_count == 0 && pending_results == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
